// ===== hw/rtl/hdcs_pkg.sv =====
// Shared constants for the hard disk collision search block.
`default_nettype none
package hdcs_pkg;

   // fixed register widths
   localparam int RADIUS_BITS   = 27;
   localparam int CELL_DIM_BITS = 31;

   // square root datapath: 2*sigma is 28 bits, its square 56 bits
   localparam int ROOT_BITS       = RADIUS_BITS + 1;
   localparam int ARG_BITS        = 2 * ROOT_BITS;
   localparam int ROOT_COUNT_BITS = $clog2(ROOT_BITS + 1);

   // register map
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISK_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CELL_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CELL_HEIGHT = 2'd2;

   localparam logic [RADIUS_BITS-1:0]   RADIUS_RESET = 27'd8388608;
   localparam logic [CELL_DIM_BITS-1:0] CELL_RESET   = 31'd16777216;

   // candidate cell offsets
   localparam int REGION_BITS = 3;
   localparam logic [REGION_BITS-1:0] REGION_SAME = 3'd0;
   localparam logic [REGION_BITS-1:0] REGION_X    = 3'd1;
   localparam logic [REGION_BITS-1:0] REGION_YM   = 3'd2;
   localparam logic [REGION_BITS-1:0] REGION_YP   = 3'd3;
   localparam logic [REGION_BITS-1:0] REGION_XYM  = 3'd4;
   localparam logic [REGION_BITS-1:0] REGION_XYP  = 3'd5;

endpackage
`default_nettype wire

// ===== hw/rtl/hdcs_isqrt.sv =====
// Iterative floor square root, one root bit per cycle.
`default_nettype none
module hdcs_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hdcs_pkg::ARG_BITS-1:0] arg,
   output logic                               done,
   output logic [hdcs_pkg::ROOT_BITS-1:0]     root
);

   localparam int RB = hdcs_pkg::ROOT_BITS;
   localparam int AB = hdcs_pkg::ARG_BITS;
   localparam int CB = hdcs_pkg::ROOT_COUNT_BITS;

   logic [AB-1:0] arg_ff,   arg_in;
   logic [RB+1:0] rem_ff,   rem_in;
   logic [RB-1:0] root_ff,  root_in;
   logic [CB-1:0] count_ff, count_in;
   logic          busy_ff,  busy_in;

   logic [RB+1:0] rem_sh;
   logic [RB+1:0] trial;

   // remainder stays below 2^RB while bits are still pending
   assign rem_sh = {rem_ff[RB-1:0], arg_ff[AB-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign done   = busy_ff && (count_ff == CB'(1));
   assign root   = root_ff;

   always_comb begin
      arg_in   = arg_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         arg_in   = arg;
         rem_in   = '0;
         root_in  = '0;
         count_in = CB'(RB);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         arg_in   = {arg_ff[AB-3:0], 2'b00};
         count_in = count_ff - CB'(1);
         if (count_ff == CB'(1)) begin
            busy_in = 1'b0;
         end
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RB-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      arg_ff  <= arg_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/hdcs_geom.sv =====
// Candidate offset, |dy| and collision qualification, registered.
`default_nettype none
module hdcs_geom #(
   parameter int COORD_BITS = 32,
   parameter int DIFF_BITS  = 34
) (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic                               has_cand,
   input  wire logic [hdcs_pkg::REGION_BITS-1:0]   region,
   input  wire logic signed [COORD_BITS-1:0]       cand_x,
   input  wire logic signed [COORD_BITS-1:0]       cand_y,
   input  wire logic signed [COORD_BITS-1:0]       moving_x,
   input  wire logic signed [COORD_BITS-1:0]       moving_y,
   input  wire logic [hdcs_pkg::RADIUS_BITS-1:0]   disk_radius,
   input  wire logic [hdcs_pkg::CELL_DIM_BITS-1:0] cell_width,
   input  wire logic [hdcs_pkg::CELL_DIM_BITS-1:0] cell_height,
   output logic signed [DIFF_BITS-1:0]             dx_ff,
   output logic [hdcs_pkg::ROOT_BITS-1:0]          ady_ff,
   output logic                                    qualify_ff
);

   localparam int EXT = DIFF_BITS - COORD_BITS;
   localparam int DEXT = DIFF_BITS - hdcs_pkg::CELL_DIM_BITS;

   logic signed [DIFF_BITS-1:0] dx_base, dy_base, dx, dy;
   logic signed [DIFF_BITS-1:0] width_ext, height_ext;
   logic [DIFF_BITS-1:0]        ady;
   logic [hdcs_pkg::ROOT_BITS-1:0] two_s;
   logic xshift, region_ok, qualify;

   assign dx_base = {{EXT{cand_x[COORD_BITS-1]}}, cand_x}
                  - {{EXT{moving_x[COORD_BITS-1]}}, moving_x};
   assign dy_base = {{EXT{cand_y[COORD_BITS-1]}}, cand_y}
                  - {{EXT{moving_y[COORD_BITS-1]}}, moving_y};
   assign width_ext  = {{DEXT{1'b0}}, cell_width};
   assign height_ext = {{DEXT{1'b0}}, cell_height};
   assign two_s      = {disk_radius, 1'b0};

   always_comb begin
      xshift    = region inside {hdcs_pkg::REGION_X, hdcs_pkg::REGION_XYM,
                                 hdcs_pkg::REGION_XYP};
      region_ok = (region <= hdcs_pkg::REGION_XYP);
      if (region inside {hdcs_pkg::REGION_YM, hdcs_pkg::REGION_XYM}) begin
         dy = dy_base - height_ext;
      end else if (region inside {hdcs_pkg::REGION_YP, hdcs_pkg::REGION_XYP}) begin
         dy = dy_base + height_ext;
      end else begin
         dy = dy_base;
      end
      dx  = xshift ? (dx_base + width_ext) : dx_base;
      ady = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
      // same-cell and pure y neighbors must lie ahead in x
      qualify = has_cand && region_ok
             && (ady < {{(DIFF_BITS-hdcs_pkg::ROOT_BITS){1'b0}}, two_s})
             && (xshift || (!dx[DIFF_BITS-1] && (dx != '0)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff      <= dx;
         ady_ff     <= ady[hdcs_pkg::ROOT_BITS-1:0];
         qualify_ff <= qualify;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/hard_disk_collision_search_top.sv =====
// Top level of the hard disk collision search: sequencer, state and channels.
//
// Usage: a search is a run of request words. The word with first_item set
// loads the moving disk (cur_x, cur_y) and the start bound; every word with
// has_candidate set is tested against the moving disk. The word with tlast
// set produces one response word: hit flag, nearest distance, cell and slot.
// Registers (disk radius, cell width, cell height) are written through the csr
// port; users must write them while no search word is in flight (not enforced).
//
// Timing: a word is taken only while the sequencer is idle. From one accept
// to the next, a word whose candidate does not qualify goes through geometry,
// qualify check, done and idle; a qualifying one goes through geometry, two
// shared-squarer passes (2*sigma squared, then |dy| squared), root load,
// bit-serial square root, compare, done and idle. The root unit sets the
// rate. The response sits in an output register; the next word is accepted
// while it waits, and the sequencer holds in done only if a second response is
// ready before the first is taken, until rsp_tready frees the register.
// Reset (synchronous) restores the register defaults, clears the search
// state to zero and drops rsp_tvalid.
`default_nettype none
module hard_disk_collision_search_top #(
   parameter int COORD_BITS      = 32,
   parameter int CELL_INDEX_BITS = 16,
   parameter int SLOT_BITS       = 6
) (
   input  wire logic clock,
   input  wire logic reset,

   // request channel
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata, low bit up: cur_x, cur_y, start_bound, cand_x, cand_y, cand_cell,
   // cand_slot, zero fill
   input  wire logic [((5*COORD_BITS+CELL_INDEX_BITS+SLOT_BITS+7)/8)*8-1:0] req_tdata,
   // tuser, low bit up: first_item, has_candidate, region[2:0]
   input  wire logic [4:0] req_tuser,
   input  wire logic       req_tlast,    // last_item

   // response channel
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata, low bit up: best_distance, hit_cell, hit_slot, zero fill
   output logic [((COORD_BITS+CELL_INDEX_BITS+SLOT_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: hit_found
   output logic [0:0] rsp_tuser,

   // register write port
   input  wire logic                                  csr_we,
   input  wire logic [hdcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [hdcs_pkg::CELL_DIM_BITS-1:0]    csr_wdata
);

   localparam int C   = COORD_BITS;
   localparam int CI  = CELL_INDEX_BITS;
   localparam int SB  = SLOT_BITS;
   localparam int RB  = hdcs_pkg::ROOT_BITS;
   localparam int AB  = hdcs_pkg::ARG_BITS;
   localparam int CD  = (C > hdcs_pkg::CELL_DIM_BITS) ? C : hdcs_pkg::CELL_DIM_BITS;
   localparam int DW  = CD + 2;
   localparam int OUT_TDATA_BITS = ((C + CI + SB + 7) / 8) * 8;

   // saturation limits of the distance, at the width of dx - root
   localparam logic signed [DW:0] SAT_HI = {{(DW + 2 - C){1'b0}}, {(C - 1){1'b1}}};
   localparam logic signed [DW:0] SAT_LO = ~SAT_HI;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GEOM  = 3'd1;
   localparam logic [2:0] ST_MULA  = 3'd2;
   localparam logic [2:0] ST_MULB  = 3'd3;
   localparam logic [2:0] ST_START = 3'd4;
   localparam logic [2:0] ST_ROOT  = 3'd5;
   localparam logic [2:0] ST_CMP   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   // configuration
   logic [hdcs_pkg::RADIUS_BITS-1:0]   disk_radius_ff;
   logic [hdcs_pkg::CELL_DIM_BITS-1:0] cell_width_ff, cell_height_ff;

   // search state
   logic signed [C-1:0] moving_x_ff, moving_y_ff, running_min_ff;
   logic [CI-1:0]       best_cell_ff;
   logic [SB-1:0]       best_slot_ff;
   logic                found_ff;

   // captured candidate word
   logic signed [C-1:0] cand_x_ff, cand_y_ff;
   logic [CI-1:0]       cand_cell_ff;
   logic [SB-1:0]       cand_slot_ff;
   logic [hdcs_pkg::REGION_BITS-1:0] region_ff;
   logic                has_ff, last_ff;

   // response register
   logic                rsp_valid_ff;
   logic signed [C-1:0] rsp_dist_ff;
   logic [CI-1:0]       rsp_cell_ff;
   logic [SB-1:0]       rsp_slot_ff;
   logic                rsp_found_ff;

   // datapath
   logic signed [DW-1:0] dx;
   logic [RB-1:0]        ady;
   logic                 qualify;
   logic [RB-1:0]        mul_op;
   logic [AB-1:0]        prod;
   logic [AB-1:0]        sq_ff, prod_ff;
   logic [RB-1:0]        root;
   logic                 root_done;
   logic signed [DW:0]   dist_wide;
   logic signed [C-1:0]  free_dist;
   logic                 accept, rsp_load, better;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   hdcs_geom #(
      .COORD_BITS (C),
      .DIFF_BITS  (DW)
   ) u_geom (
      .clock       (clock),
      .en          (state_ff == ST_GEOM),
      .has_cand    (has_ff),
      .region      (region_ff),
      .cand_x      (cand_x_ff),
      .cand_y      (cand_y_ff),
      .moving_x    (moving_x_ff),
      .moving_y    (moving_y_ff),
      .disk_radius (disk_radius_ff),
      .cell_width  (cell_width_ff),
      .cell_height (cell_height_ff),
      .dx_ff       (dx),
      .ady_ff      (ady),
      .qualify_ff  (qualify)
   );

   // shared squarer: (2*sigma)^2 first, then |dy|^2
   assign mul_op = (state_ff == ST_MULA) ? {disk_radius_ff, 1'b0} : ady;
   assign prod   = {{RB{1'b0}}, mul_op} * {{RB{1'b0}}, mul_op};

   hdcs_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_START),
      .arg   (sq_ff - prod_ff),
      .done  (root_done),
      .root  (root)
   );

   always_comb begin
      dist_wide = {dx[DW-1], dx} - {{(DW + 1 - RB){1'b0}}, root};
      if (dist_wide > SAT_HI) begin
         free_dist = SAT_HI[C-1:0];
      end else if (dist_wide < SAT_LO) begin
         free_dist = SAT_LO[C-1:0];
      end else begin
         free_dist = dist_wide[C-1:0];
      end
      better = (free_dist < running_min_ff);   // ties keep the earlier hit
   end

   assign rsp_load = (state_ff == ST_DONE) && last_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_GEOM;
         ST_GEOM:  state_in = ST_MULA;
         // geometry result is registered here; only qualifying candidates
         // take the long path
         ST_MULA:  state_in = qualify ? ST_MULB : ST_DONE;
         ST_MULB:  state_in = ST_START;
         ST_START: state_in = ST_ROOT;
         ST_ROOT:  if (root_done) state_in = ST_CMP;
         ST_CMP:   state_in = ST_DONE;
         ST_DONE: begin
            if (!last_ff || rsp_load) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         disk_radius_ff <= hdcs_pkg::RADIUS_RESET;
         cell_width_ff  <= hdcs_pkg::CELL_RESET;
         cell_height_ff <= hdcs_pkg::CELL_RESET;
         moving_x_ff    <= '0;
         moving_y_ff    <= '0;
         running_min_ff <= '0;
         best_cell_ff   <= '0;
         best_slot_ff   <= '0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               hdcs_pkg::CSR_DISK_RADIUS:
                  disk_radius_ff <= csr_wdata[hdcs_pkg::RADIUS_BITS-1:0];
               hdcs_pkg::CSR_CELL_WIDTH:  cell_width_ff  <= csr_wdata;
               hdcs_pkg::CSR_CELL_HEIGHT: cell_height_ff <= csr_wdata;
               default: ;
            endcase
         end

         // first word reloads before its own candidate is tested
         if (accept && req_tuser[0]) begin
            moving_x_ff    <= req_tdata[C-1:0];
            moving_y_ff    <= req_tdata[2*C-1:C];
            running_min_ff <= req_tdata[3*C-1:2*C];
            best_cell_ff   <= '0;
            best_slot_ff   <= '0;
            found_ff       <= 1'b0;
         end else if (state_ff == ST_CMP && better) begin
            running_min_ff <= free_dist;
            best_cell_ff   <= cand_cell_ff;
            best_slot_ff   <= cand_slot_ff;
            found_ff       <= 1'b1;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         cand_x_ff    <= req_tdata[4*C-1:3*C];
         cand_y_ff    <= req_tdata[5*C-1:4*C];
         cand_cell_ff <= req_tdata[5*C+CI-1:5*C];
         cand_slot_ff <= req_tdata[5*C+CI+SB-1:5*C+CI];
         has_ff       <= req_tuser[1];
         region_ff    <= req_tuser[4:2];
         last_ff      <= req_tlast;
      end

      if (state_ff == ST_MULA) sq_ff   <= prod;
      if (state_ff == ST_MULB) prod_ff <= prod;

      if (rsp_load) begin
         rsp_dist_ff  <= running_min_ff;
         rsp_cell_ff  <= best_cell_ff;
         rsp_slot_ff  <= best_slot_ff;
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_TDATA_BITS'({rsp_slot_ff, rsp_cell_ff, rsp_dist_ff});
   assign rsp_tuser  = rsp_found_ff;

endmodule
`default_nettype wire
